// ===== src/cle_pkg.sv =====
// Shared constants of the circular list engine: defaults, operation and status codes.
`default_nettype none
package cle_pkg;
	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] OP_INS_TAIL = 3'd0;
	localparam logic [2:0] OP_INS_HEAD = 3'd1;
	localparam logic [2:0] OP_REWIND   = 3'd2;
	localparam logic [2:0] OP_ADVANCE  = 3'd3;
	localparam logic [2:0] OP_REMOVE   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NOCUR = 2'd3;
endpackage
`default_nettype wire

// ===== src/cle_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/cle_out.sv =====
// Result holding register between the sequencer and the result channel.
`default_nettype none
module cle_out #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 9
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load_valid,
	output logic                       load_ready,
	input  wire logic [DATA_WIDTH-1:0] load_data,
	input  wire logic [1:0]            load_status,
	input  wire logic [CNT_W-1:0]      load_count,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic      [DATA_WIDTH-1:0] data_out,
	output logic      [1:0]            status,
	output logic      [CNT_W-1:0]      element_count
);
	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [1:0]            status_q;
	logic [CNT_W-1:0]      count_q;

	assign load_ready = !valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_q   <= load_data;
			status_q <= load_status;
			count_q  <= load_count;
		end
	end

	assign rsp_valid     = valid_q;
	assign data_out      = data_q;
	assign status        = status_q;
	assign element_count = count_q;
endmodule
`default_nettype wire

// ===== src/cle_seq.sv =====
// Request sequencer: list pointers, free list and read-modify-write of the node RAMs.
`default_nettype none
module cle_seq
	import cle_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int SLOT_W    = $clog2(CAPACITY),
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [2:0]            op,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic      [DATA_WIDTH-1:0] res_data,
	output logic      [1:0]            res_status,
	output logic      [CNT_W-1:0]      res_count,
	output logic                       lk_we,
	output logic      [SLOT_W-1:0]     lk_waddr,
	output logic      [SLOT_W-1:0]     lk_wdata,
	output logic      [SLOT_W-1:0]     lk_raddr,
	input  wire logic [SLOT_W-1:0]     lk_rdata,
	output logic                       vl_we,
	output logic      [SLOT_W-1:0]     vl_waddr,
	output logic      [DATA_WIDTH-1:0] vl_wdata,
	output logic      [SLOT_W-1:0]     vl_raddr,
	input  wire logic [DATA_WIDTH-1:0] vl_rdata
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_STEP2 = 4'b0100,
		S_DONE  = 4'b1000
	} seq_state_t;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	seq_state_t            state_q;
	logic [2:0]            op_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] res_data_q;
	logic [1:0]            res_status_q;
	logic [SLOT_W-1:0]     tail_q;
	logic [SLOT_W-1:0]     head_q;
	logic [SLOT_W-1:0]     cursor_q;
	logic [SLOT_W-1:0]     prior_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     free_head_q;
	logic                  free_ne_q;
	logic                  cur_ready_q;
	logic                  started_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      fresh_q;

	logic                  is_ins;
	logic                  q_ins;
	logic [SLOT_W-1:0]     new_slot;
	logic [CNT_W-1:0]      fresh_nx;
	logic [CNT_W-1:0]      count_inc;

	assign is_ins    = (op == OP_INS_TAIL) || (op == OP_INS_HEAD);
	assign q_ins     = (op_q == OP_INS_TAIL) || (op_q == OP_INS_HEAD);
	assign new_slot  = free_ne_q ? free_head_q : fresh_q[SLOT_W-1:0];
	assign fresh_nx  = free_ne_q ? fresh_q : fresh_q + 1'b1;
	assign count_inc = count_q + 1'b1;

	assign req_ready  = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_data   = res_data_q;
	assign res_status = res_status_q;
	assign res_count  = count_q;

	always_comb begin
		lk_raddr = is_ins ? free_head_q : cursor_q;
		vl_raddr = (state_q == S_EXEC) ? lk_rdata :
			((op == OP_REWIND) ? head_q : cursor_q);
		lk_we    = 1'b0;
		lk_waddr = slot_q;
		lk_wdata = free_head_q;
		vl_we    = 1'b0;
		vl_waddr = new_slot;
		vl_wdata = data_q;
		case (state_q)
			S_EXEC: begin
				if (q_ins) begin
					vl_we    = 1'b1;
					lk_we    = 1'b1;
					lk_waddr = new_slot;
					lk_wdata = (count_q == '0) ? new_slot : head_q;
				end else if (op_q == OP_REMOVE) begin
					lk_we    = 1'b1;
					lk_waddr = prior_q;
					lk_wdata = lk_rdata;
				end
			end
			S_STEP2: begin
				if (q_ins) begin
					lk_we    = 1'b1;
					lk_waddr = tail_q;
					lk_wdata = slot_q;
				end else if (op_q == OP_REMOVE) begin
					lk_we    = 1'b1;
					lk_waddr = slot_q;
					lk_wdata = free_head_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tail_q      <= '0;
			head_q      <= '0;
			cursor_q    <= '0;
			prior_q     <= '0;
			free_head_q <= '0;
			free_ne_q   <= 1'b0;
			cur_ready_q <= 1'b0;
			started_q   <= 1'b0;
			count_q     <= '0;
			fresh_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
						case (op)
							OP_INS_TAIL, OP_INS_HEAD: begin
								if (count_q == CAP_CNT) state_q <= S_DONE;
							end
							OP_REWIND: begin
								if (count_q == '0) state_q <= S_DONE;
							end
							OP_ADVANCE: begin
								if (count_q == '0 || !started_q) state_q <= S_DONE;
							end
							OP_REMOVE: begin
								if (count_q == '0 || !cur_ready_q) state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_EXEC: begin
					case (op_q)
						OP_INS_TAIL, OP_INS_HEAD: begin
							if (free_ne_q) free_head_q <= lk_rdata;
							fresh_q   <= fresh_nx;
							count_q   <= count_inc;
							free_ne_q <= (fresh_nx != count_inc);
							if (count_q == '0) begin
								tail_q  <= new_slot;
								head_q  <= new_slot;
								state_q <= S_DONE;
							end else begin
								state_q <= S_STEP2;
							end
						end
						OP_REWIND: begin
							prior_q     <= tail_q;
							cursor_q    <= head_q;
							cur_ready_q <= 1'b1;
							started_q   <= 1'b1;
							state_q     <= S_DONE;
						end
						OP_ADVANCE: begin
							prior_q     <= cursor_q;
							cursor_q    <= lk_rdata;
							cur_ready_q <= 1'b1;
							state_q     <= S_STEP2;
						end
						OP_REMOVE: begin
							if (count_q == CNT_W'(1)) begin
								tail_q    <= '0;
								started_q <= 1'b0;
							end else if (cursor_q == tail_q) begin
								tail_q <= prior_q;
							end
							if (cursor_q == head_q) head_q <= lk_rdata;
							cursor_q    <= prior_q;
							cur_ready_q <= 1'b0;
							count_q     <= count_q - 1'b1;
							free_ne_q   <= 1'b1;
							state_q     <= S_STEP2;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_STEP2: begin
					if (q_ins) begin
						if (cur_ready_q && prior_q == tail_q) prior_q <= slot_q;
						if (op_q == OP_INS_TAIL) begin
							tail_q <= slot_q;
						end else begin
							head_q <= slot_q;
						end
					end else if (op_q == OP_REMOVE) begin
						free_head_q <= slot_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= op;
				data_q       <= data_in;
				res_data_q   <= '0;
				res_status_q <= ST_OK;
				case (op)
					OP_INS_TAIL, OP_INS_HEAD: begin
						if (count_q == CAP_CNT) res_status_q <= ST_FULL;
					end
					OP_REWIND: begin
						if (count_q == '0) res_status_q <= ST_EMPTY;
					end
					OP_ADVANCE: begin
						if (count_q == '0) res_status_q <= ST_EMPTY;
						else if (!started_q) res_status_q <= ST_NOCUR;
					end
					OP_REMOVE: begin
						if (count_q == '0) res_status_q <= ST_EMPTY;
						else if (!cur_ready_q) res_status_q <= ST_NOCUR;
					end
					default: begin
					end
				endcase
			end
			S_EXEC: begin
				if (q_ins) slot_q <= new_slot;
				if (op_q == OP_REMOVE) slot_q <= cursor_q;
				if (op_q == OP_REWIND || op_q == OP_REMOVE) res_data_q <= vl_rdata;
			end
			S_STEP2: begin
				if (op_q == OP_ADVANCE) res_data_q <= vl_rdata;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== src/circular_list_engine.sv =====
// Top level of the circular list engine: node RAMs, sequencer and result register.
//
// A circular singly linked list of up to CAPACITY values kept in two node RAMs
// (values and next links) with a registered read. Each request is one
// operation: append at tail, insert at head, rewind, advance, or remove at the
// cursor; each gives one response with the value read or removed, a status and
// the element count. Requests are handled one at a time: a request that is
// refused or has no effect goes to DONE, a rewind or an insert into an empty
// list passes through EXEC, any other insert, an advance or a remove through
// EXEC and STEP2, set by the dependent RAM accesses (read, then two link writes
// through the single write port, or a link read followed by a value read). The
// response sits in an output register, so the next request is taken while it
// waits. Node RAM contents are not cleared by reset and need no clearing pass.
`default_nettype none
module circular_list_engine
	import cle_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int SLOT_W    = $clog2(CAPACITY),
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [2:0]            op,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic      [DATA_WIDTH-1:0] data_out,
	output logic      [1:0]            status,
	output logic      [CNT_W-1:0]      element_count
);
	logic                  res_valid;
	logic                  res_ready;
	logic [DATA_WIDTH-1:0] res_data;
	logic [1:0]            res_status;
	logic [CNT_W-1:0]      res_count;
	logic                  lk_we;
	logic [SLOT_W-1:0]     lk_waddr;
	logic [SLOT_W-1:0]     lk_wdata;
	logic [SLOT_W-1:0]     lk_raddr;
	logic [SLOT_W-1:0]     lk_rdata;
	logic                  vl_we;
	logic [SLOT_W-1:0]     vl_waddr;
	logic [DATA_WIDTH-1:0] vl_wdata;
	logic [SLOT_W-1:0]     vl_raddr;
	logic [DATA_WIDTH-1:0] vl_rdata;

	cle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	cle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
		.clk   (clk),
		.we    (vl_we),
		.waddr (vl_waddr),
		.wdata (vl_wdata),
		.raddr (vl_raddr),
		.rdata (vl_rdata)
	);

	cle_seq #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.op         (op),
		.data_in    (data_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.res_status (res_status),
		.res_count  (res_count),
		.lk_we      (lk_we),
		.lk_waddr   (lk_waddr),
		.lk_wdata   (lk_wdata),
		.lk_raddr   (lk_raddr),
		.lk_rdata   (lk_rdata),
		.vl_we      (vl_we),
		.vl_waddr   (vl_waddr),
		.vl_wdata   (vl_wdata),
		.vl_raddr   (vl_raddr),
		.vl_rdata   (vl_rdata)
	);

	cle_out #(.DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W)) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_valid    (res_valid),
		.load_ready    (res_ready),
		.load_data     (res_data),
		.load_status   (res_status),
		.load_count    (res_count),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.data_out      (data_out),
		.status        (status),
		.element_count (element_count)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> element_count <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> element_count == CNT_W'(CAPACITY))
		else $error("full status with free space");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> element_count == '0)
		else $error("empty status with elements stored");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !lk_we && !vl_we)
		else $error("node write while idle");
endmodule
`default_nettype wire

// ===== tb/circular_list_engine_test.sv =====
// Self-checking testbench of the circular list engine: directed table, then random list traffic.
`timescale 1ns / 100ps
module circular_list_engine_test;
	import cle_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int CNT_W       = $clog2(CAPACITY_DEF + 1);
	localparam int RAND_ITEMS  = 320;
	localparam int HOLD_CYCLES = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRILL_LEN   = 27;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [31:0]      value;
		logic [1:0]       code;
		logic [CNT_W-1:0] count;
	} list_answer_t;

	typedef struct packed {
		logic [2:0]       code;
		logic [31:0]      value;
		logic [15:0]      reps;
		logic             typed;
		logic [31:0]      want_value;
		logic [1:0]       want_code;
		logic [CNT_W-1:0] want_count;
	} stim_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             rsp_ready = 1'b0;
	logic [2:0]       op        = 3'd0;
	logic [31:0]      data_in   = 32'd0;
	logic             req_ready;
	logic             rsp_valid;
	logic [31:0]      data_out;
	logic [1:0]       status;
	logic [CNT_W-1:0] element_count;

	// list image
	logic [31:0]      node_value [CAP];
	logic [7:0]       node_link  [CAP];
	logic [7:0]       tail_idx     = '0;
	logic [7:0]       cursor_idx   = '0;
	logic [7:0]       prior_idx    = '0;
	logic             cursor_live  = 1'b0;
	logic             cursor_begun = 1'b0;
	logic [CNT_W-1:0] elem_cnt     = '0;
	logic [7:0]       free_top     = '0;
	logic             free_any     = 1'b0;
	logic [CNT_W-1:0] fresh_cnt    = '0;

	list_answer_t pending_answers [$];
	int           mismatch_count = 0;
	int           sent_count     = 0;
	int           answers_seen   = 0;
	int           cycle_count    = 0;

	stim_row_t drill_rows [DRILL_LEN] = '{
		'{OP_ADVANCE,  32'h0,        16'd1,   1'b1, 32'h0,        ST_EMPTY, 9'd0},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b1, 32'h0,        ST_EMPTY, 9'd0},
		'{OP_REWIND,   32'h0,        16'd1,   1'b1, 32'h0,        ST_EMPTY, 9'd0},
		'{OP_SPARE_LO, 32'hFFFFFFFF, 16'd1,   1'b1, 32'h0,        ST_OK,    9'd0},
		'{OP_SPARE_HI, 32'h0,        16'd1,   1'b1, 32'h0,        ST_OK,    9'd0},
		'{OP_INS_TAIL, 32'h0,        16'd1,   1'b1, 32'h0,        ST_OK,    9'd1},
		'{OP_ADVANCE,  32'h0,        16'd1,   1'b1, 32'h0,        ST_NOCUR, 9'd1},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b1, 32'h0,        ST_NOCUR, 9'd1},
		'{OP_INS_HEAD, 32'hFFFFFFFF, 16'd1,   1'b1, 32'h0,        ST_OK,    9'd2},
		'{OP_REWIND,   32'h0,        16'd1,   1'b1, 32'hFFFFFFFF, ST_OK,    9'd2},
		'{OP_INS_TAIL, 32'hA5A5A5A5, 16'd1,   1'b1, 32'h0,        ST_OK,    9'd3},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b1, 32'hFFFFFFFF, ST_OK,    9'd2},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b1, 32'h0,        ST_NOCUR, 9'd2},
		'{OP_ADVANCE,  32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_ADVANCE,  32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_ADVANCE,  32'h0,        16'd1,   1'b1, 32'h0,        ST_EMPTY, 9'd0},
		'{OP_INS_HEAD, 32'h12345678, 16'd1,   1'b1, 32'h0,        ST_OK,    9'd1},
		'{OP_ADVANCE,  32'h0,        16'd1,   1'b1, 32'h0,        ST_NOCUR, 9'd1},
		'{OP_INS_HEAD, 32'h80000000, 16'd256, 1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_INS_TAIL, 32'h7FFFFFFF, 16'd1,   1'b1, 32'h0,        ST_FULL,  9'd256},
		'{OP_REWIND,   32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_ADVANCE,  32'h0,        16'd300, 1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_INS_HEAD, 32'h5A5A5A5A, 16'd1,   1'b0, 32'h0,        ST_OK,    9'd0},
		'{OP_REMOVE,   32'h0,        16'd1,   1'b0, 32'h0,        ST_OK,    9'd0}
	};

	circular_list_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.op            (op),
		.data_in       (data_in),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.data_out      (data_out),
		.status        (status),
		.element_count (element_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void predict_list_op(input logic [2:0] code, input logic [31:0] value,
			output list_answer_t ans);
		logic [7:0] slot;
		logic [7:0] victim;
		logic [7:0] prev;
		ans = '{value: 32'h0, code: ST_OK, count: '0};
		case (code)
			OP_INS_TAIL, OP_INS_HEAD: begin
				if (elem_cnt >= CAP) begin
					ans.code = ST_FULL;
				end else begin
					if (free_any) begin
						slot = free_top;
						free_top = node_link[slot];
					end else begin
						slot = fresh_cnt[7:0];
						fresh_cnt = fresh_cnt + 1'b1;
					end
					node_value[slot] = value;
					if (elem_cnt == 0) begin
						tail_idx = slot;
						node_link[slot] = slot;
					end else begin
						node_link[slot] = node_link[tail_idx];
						node_link[tail_idx] = slot;
						if (cursor_live && prior_idx == tail_idx)
							prior_idx = slot;
						if (code == OP_INS_TAIL)
							tail_idx = slot;
					end
					elem_cnt = elem_cnt + 1'b1;
					free_any = (fresh_cnt != elem_cnt);
				end
			end
			OP_REWIND: begin
				if (elem_cnt == 0) begin
					ans.code = ST_EMPTY;
				end else begin
					prior_idx = tail_idx;
					cursor_idx = node_link[prior_idx];
					cursor_live = 1'b1;
					cursor_begun = 1'b1;
					ans.value = node_value[cursor_idx];
				end
			end
			OP_ADVANCE: begin
				if (elem_cnt == 0) begin
					ans.code = ST_EMPTY;
				end else if (!cursor_begun) begin
					ans.code = ST_NOCUR;
				end else begin
					prior_idx = cursor_idx;
					cursor_idx = node_link[prior_idx];
					cursor_live = 1'b1;
					ans.value = node_value[cursor_idx];
				end
			end
			OP_REMOVE: begin
				if (elem_cnt == 0) begin
					ans.code = ST_EMPTY;
				end else if (!cursor_live) begin
					ans.code = ST_NOCUR;
				end else begin
					victim = cursor_idx;
					prev = prior_idx;
					ans.value = node_value[victim];
					if (victim == tail_idx && elem_cnt > 1)
						tail_idx = prev;
					node_link[prev] = node_link[victim];
					cursor_idx = prev;
					cursor_live = 1'b0;
					node_link[victim] = free_top;
					free_top = victim;
					free_any = 1'b1;
					elem_cnt = elem_cnt - 1'b1;
					if (elem_cnt == 0) begin
						cursor_begun = 1'b0;
						tail_idx = '0;
					end
				end
			end
			default: ;
		endcase
		ans.count = elem_cnt;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		$display("mismatch %0d at response %0d: %s got %h want %h",
			mismatch_count, answers_seen, what, got, want);
	endtask

	task automatic issue_request(input logic [2:0] code, input logic [31:0] value, input logic typed,
			input logic [31:0] want_value, input logic [1:0] want_code,
			input logic [CNT_W-1:0] want_count);
		int gap;
		list_answer_t ans;
		gap = (sent_count % 200 >= 150) ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= code;
		data_in <= value;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_list_op(code, value, ans);
		if (typed)
			ans = '{value: want_value, code: want_code, count: want_count};
		pending_answers.push_back(ans);
		sent_count++;
	endtask

	// response side
	initial begin
		int wait_cycles;
		list_answer_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = (answers_seen % 170 >= 120) ? 0 : $urandom_range(0, 3);
			if (answers_seen == 250 || answers_seen == 800)
				wait_cycles = HOLD_CYCLES;
			if (wait_cycles != 0) begin
				rsp_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			if (pending_answers.size() == 0) begin
				flag_mismatch("unexpected response, data_out", data_out, 32'h0);
			end else begin
				want = pending_answers.pop_front();
				if (data_out !== want.value)
					flag_mismatch("data_out", data_out, want.value);
				if (status !== want.code)
					flag_mismatch("status", 32'(status), 32'(want.code));
				if (element_count !== want.count)
					flag_mismatch("element_count", 32'(element_count), 32'(want.count));
			end
			answers_seen++;
		end
	end

	// request side
	initial begin
		int r;
		int k;
		int n;
		int left;
		int pick;
		logic grow;
		logic [2:0] code;
		logic [2:0] last_code;
		logic [31:0] value;
		left = 0;
		grow = 1'b1;
		last_code = OP_REWIND;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DRILL_LEN; r++)
			for (k = 0; k < int'(drill_rows[r].reps); k++)
				issue_request(drill_rows[r].code, drill_rows[r].value + 32'(k),
					drill_rows[r].typed, drill_rows[r].want_value,
					drill_rows[r].want_code, drill_rows[r].want_count);

		for (n = 0; n < RAND_ITEMS; n++) begin
			if (left == 0) begin
				if (elem_cnt < 30)
					grow = 1'b1;
				else if (elem_cnt > 200)
					grow = 1'b0;
				else
					grow = 1'($urandom_range(0, 1));
				left = $urandom_range(20, 120);
			end
			left--;
			pick = $urandom_range(0, 99);
			if (grow) begin
				if (pick < 30)
					code = OP_INS_TAIL;
				else if (pick < 55)
					code = OP_INS_HEAD;
				else if (pick < 65)
					code = OP_REWIND;
				else if (pick < 85)
					code = OP_ADVANCE;
				else if (pick < 98)
					code = OP_REMOVE;
				else
					code = OP_SPARE_LO + 3'($urandom_range(0, 2));
			end else begin
				// refresh the cursor after a remove, mostly
				if (last_code == OP_REMOVE && pick >= 15)
					code = OP_ADVANCE;
				else if (pick < 5)
					code = OP_INS_TAIL;
				else if (pick < 10)
					code = OP_INS_HEAD;
				else if (pick < 20)
					code = OP_REWIND;
				else if (pick < 55)
					code = OP_ADVANCE;
				else if (pick < 98)
					code = OP_REMOVE;
				else
					code = OP_SPARE_LO + 3'($urandom_range(0, 2));
			end
			case ($urandom_range(0, 7))
				0: value = 32'h0;
				1: value = 32'hFFFFFFFF;
				default: value = $urandom;
			endcase
			issue_request(code, value, 1'b0, 32'h0, ST_OK, '0);
			last_code = code;
		end
		req_valid <= 1'b0;

		while (pending_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/cle_pkg.sv
src/cle_ram.sv
src/cle_out.sv
src/cle_seq.sv
src/circular_list_engine.sv
tb/circular_list_engine_test.sv
